// File: hdl/mktd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mktd_pkg: shared types, constants and the pattern table
// Widths, register indexes, the character bundle carried from the front
// end to the back end, and the element pattern lookup.
// ----------------------------------------------------------------------------
package mktd_pkg;

  // counter and register widths
  localparam int CountWidth  = 24;
  localparam int RegWidth    = 24;
  localparam int MaxElements = 6;

  localparam logic [CountWidth-1:0] CountTop = {CountWidth{1'b1}};

  // register indexes
  localparam logic [1:0] RegElementEndGap = 2'd0;
  localparam logic [1:0] RegDotMax        = 2'd1;
  localparam logic [1:0] RegLetterGap     = 2'd2;
  localparam logic [1:0] RegWordGap       = 2'd3;

  // reset values of the registers
  localparam logic [RegWidth-1:0] ElementEndGapRst = RegWidth'(110);
  localparam logic [RegWidth-1:0] DotMaxRst        = RegWidth'(550);
  localparam logic [RegWidth-1:0] LetterGapRst     = RegWidth'(1815);
  localparam logic [RegWidth-1:0] WordGapRst       = RegWidth'(2750);

  // characters
  localparam logic [6:0] CharSpace = 7'h20;

  // queue between front and back end
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);

  // configuration bundle
  typedef struct packed {
    logic [RegWidth-1:0] element_end_gap;
    logic [RegWidth-1:0] dot_max;
    logic [RegWidth-1:0] letter_gap;
    logic [RegWidth-1:0] word_gap;
  } cfg_t;

  // up to four characters caused by one key sample
  typedef struct packed {
    logic [2:0]      len;
    logic [3:0][6:0] ch;
  } entry_t;

  function automatic entry_t mk1(input logic [7:0] c0);
    entry_t r;
    r       = '0;
    r.len   = 3'd1;
    r.ch[0] = c0[6:0];
    return r;
  endfunction

  function automatic entry_t mk2(input logic [7:0] c0, input logic [7:0] c1);
    entry_t r;
    r       = '0;
    r.len   = 3'd2;
    r.ch[0] = c0[6:0];
    r.ch[1] = c1[6:0];
    return r;
  endfunction

  function automatic entry_t mk4(input logic [7:0] c0, input logic [7:0] c1,
                                 input logic [7:0] c2, input logic [7:0] c3);
    entry_t r;
    r.len   = 3'd4;
    r.ch[0] = c0[6:0];
    r.ch[1] = c1[6:0];
    r.ch[2] = c2[6:0];
    r.ch[3] = c3[6:0];
    return r;
  endfunction

  // pattern lookup: bit i of bits is element i, 1 means dash
  function automatic entry_t decode_pattern(input logic [2:0] count,
                                            input logic [MaxElements-1:0] bits);
    entry_t r;
    r = '0;
    case ({count, bits})
      {3'd1, 6'd0}:  r = mk1("E");
      {3'd1, 6'd1}:  r = mk1("T");
      {3'd2, 6'd0}:  r = mk1("I");
      {3'd2, 6'd2}:  r = mk1("A");
      {3'd2, 6'd1}:  r = mk1("N");
      {3'd2, 6'd3}:  r = mk1("M");
      {3'd3, 6'd0}:  r = mk1("S");
      {3'd3, 6'd4}:  r = mk1("U");
      {3'd3, 6'd2}:  r = mk1("R");
      {3'd3, 6'd6}:  r = mk1("W");
      {3'd3, 6'd1}:  r = mk1("D");
      {3'd3, 6'd5}:  r = mk1("K");
      {3'd3, 6'd3}:  r = mk1("G");
      {3'd3, 6'd7}:  r = mk1("O");
      {3'd4, 6'd0}:  r = mk1("H");
      {3'd4, 6'd8}:  r = mk1("V");
      {3'd4, 6'd4}:  r = mk1("F");
      {3'd4, 6'd2}:  r = mk1("L");
      {3'd4, 6'd6}:  r = mk1("P");
      {3'd4, 6'd14}: r = mk1("J");
      {3'd4, 6'd1}:  r = mk1("B");
      {3'd4, 6'd9}:  r = mk1("X");
      {3'd4, 6'd5}:  r = mk1("C");
      {3'd4, 6'd13}: r = mk1("Y");
      {3'd4, 6'd3}:  r = mk1("Z");
      {3'd4, 6'd11}: r = mk1("Q");
      {3'd5, 6'd0}:  r = mk1("5");
      {3'd5, 6'd16}: r = mk1("4");
      {3'd5, 6'd24}: r = mk1("3");
      {3'd5, 6'd28}: r = mk1("2");
      {3'd5, 6'd30}: r = mk1("1");
      {3'd5, 6'd31}: r = mk1("0");
      {3'd5, 6'd15}: r = mk1("9");
      {3'd5, 6'd7}:  r = mk1("8");
      {3'd5, 6'd3}:  r = mk1("7");
      {3'd5, 6'd1}:  r = mk1("6");
      {3'd5, 6'd13}: r = mk1("(");
      {3'd5, 6'd17}: r = mk4("<", "B", "T", ">");
      {3'd5, 6'd9}:  r = mk1("/");
      {3'd5, 6'd2}:  r = mk4("<", "A", "S", ">");
      {3'd5, 6'd10}: r = mk4("<", "A", "R", ">");
      {3'd6, 6'd0}:  r = mk1("#");
      {3'd6, 6'd42}: r = mk1(".");
      {3'd6, 6'd51}: r = mk1(",");
      {3'd6, 6'd12}: r = mk1("?");
      {3'd6, 6'd18}: r = mk2("'", "'");
      {3'd6, 6'd7}:  r = mk1(":");
      {3'd6, 6'd21}: r = mk1(";");
      {3'd6, 6'd45}: r = mk1(")");
      {3'd6, 6'd40}: r = mk4("<", "S", "K", ">");
      default:       r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: hdl/mktd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mktd_front: key timing front end
// Takes one key sample per cycle while the queue is not full, keeps the
// tick counters and element pattern, and queues each sample's characters.
// ----------------------------------------------------------------------------
module mktd_front import mktd_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  logic   full_i,
  input  logic   key_down_i,
  input  cfg_t   cfg_i,
  output logic   q_push_o,
  output entry_t q_data_o
);

  typedef enum logic [1:0] {
    PhIdle,
    PhTone,
    PhGap,
    PhWord
  } phase_e;

  phase_e                 phase_q, phase_d;
  logic [CountWidth-1:0]  down_q, down_d, up_q, up_d;
  logic [CountWidth-1:0]  down_new, up_new;
  logic [MaxElements-1:0] bits_q, bits_d;
  logic [2:0]             cnt_q, cnt_d;
  logic                   accept, cascade, decoded, dash;
  entry_t                 ent;

  function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] v);
    return (v == CountTop) ? v : v + CountWidth'(1);
  endfunction

  assign accept   = push_i && !full_i;
  assign down_new = key_down_i ? sat_inc(down_q) : down_q;
  assign up_new   = key_down_i ? up_q : sat_inc(up_q);
  assign dash     = (down_new > CountWidth'(cfg_i.dot_max));

  // next state and the characters of this sample
  always_comb begin
    phase_d = phase_q;
    down_d  = down_q;
    up_d    = up_q;
    bits_d  = bits_q;
    cnt_d   = cnt_q;
    ent     = '0;
    cascade = 1'b0;
    decoded = 1'b0;

    unique case (phase_q)
      PhIdle: begin
        if (key_down_i) begin
          down_d  = CountWidth'(1);
          up_d    = '0;
          phase_d = PhTone;
        end
      end
      PhTone: begin
        down_d = down_new;
        up_d   = up_new;
        if (up_new > CountWidth'(cfg_i.element_end_gap)) begin
          if (cnt_q < 3'd6) begin
            bits_d[cnt_q] = dash;
          end
          if (cnt_q < 3'd7) begin
            cnt_d = cnt_q + 3'd1;
          end
          phase_d = PhGap;
          cascade = 1'b1;
        end
      end
      PhGap, PhWord: begin
        if (key_down_i) begin
          down_d  = CountWidth'(1);
          up_d    = '0;
          phase_d = PhTone;
        end else begin
          up_d    = up_new;
          cascade = 1'b1;
        end
      end
      default: ;
    endcase

    // letter gap passed: decode the pattern
    if (cascade && phase_d == PhGap && up_new > CountWidth'(cfg_i.letter_gap)) begin
      ent     = decode_pattern(cnt_d, bits_d);
      bits_d  = '0;
      cnt_d   = '0;
      phase_d = PhWord;
      decoded = 1'b1;
    end

    // word gap passed: space, unless a prosign filled the slots
    if (cascade && phase_d == PhWord && up_new > CountWidth'(cfg_i.word_gap) &&
        (!decoded || ent.len < 3'd4)) begin
      ent.ch[ent.len[1:0]] = CharSpace;
      ent.len              = ent.len + 3'd1;
      phase_d              = PhIdle;
      down_d               = '0;
      up_d                 = '0;
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      down_q  <= '0;
      up_q    <= '0;
      bits_q  <= '0;
      cnt_q   <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      down_q  <= down_d;
      up_q    <= up_d;
      bits_q  <= bits_d;
      cnt_q   <= cnt_d;
    end
  end

  assign q_push_o = accept && (ent.len != 3'd0);
  assign q_data_o = ent;

endmodule

// File: hdl/mktd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mktd_queue: character bundle queue
// Short register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module mktd_queue import mktd_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t data_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   empty_o,
  output entry_t head_o
);

  entry_t               mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueuePtrW:0]   count_q;

  assign full_o  = (count_q == (QueuePtrW+1)'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (!push_i && pop_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// File: hdl/mktd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mktd_back: character emitter
// Walks the head bundle of the queue into the output register one character
// per cycle when it is empty or popped, and flags each sample's last one.
// ----------------------------------------------------------------------------
module mktd_back import mktd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_empty_i,
  input  entry_t     q_head_i,
  output logic       q_pop_o,
  input  logic       pop_i,
  output logic       valid_o,
  output logic [6:0] char_code_o,
  output logic       last_of_run_o
);

  logic [1:0] idx_q;
  logic       valid_q;
  logic [6:0] char_q;
  logic       last_q;
  logic       load, is_last;

  assign load    = (!valid_q || pop_i) && !q_empty_i;
  assign is_last = ({1'b0, idx_q} + 3'd1) == q_head_i.len;
  assign q_pop_o = load && is_last;

  // output control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load) begin
      valid_q <= 1'b1;
      idx_q   <= is_last ? 2'd0 : idx_q + 2'd1;
    end else if (pop_i) begin
      valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= q_head_i.ch[idx_q];
      last_q <= is_last;
    end
  end

  assign valid_o       = valid_q;
  assign char_code_o   = char_q;
  assign last_of_run_o = last_q;

endmodule

// File: hdl/morse_key_timing_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morse_key_timing_decoder: Morse key timing decoder
// Turns a stream of key samples into ASCII characters, prosigns and spaces.
// ----------------------------------------------------------------------------
// One key sample is taken per cycle while full is low. Each sample yields
// zero to four characters; the front end classifies a sample and drops its
// characters as one bundle into a four-entry queue, and the back end moves
// one character per cycle to the output register while that register is
// empty or popped. Silent samples sustain one sample per cycle, while a
// sample that ends a prosign needs four characters of output; full rises
// only when the queue holds four undelivered bundles. No clearing pass
// follows reset.
module morse_key_timing_decoder import mktd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic                key_down_i,
  output logic                empty,
  input  logic                pop,
  output logic [6:0]          char_code_o,
  output logic                last_of_run_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [RegWidth-1:0] cfg_wdata_i
);

  cfg_t   cfg_q;
  logic   q_push, q_full, q_pop, q_empty, out_valid;
  entry_t q_data, q_head;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.element_end_gap <= ElementEndGapRst;
      cfg_q.dot_max         <= DotMaxRst;
      cfg_q.letter_gap      <= LetterGapRst;
      cfg_q.word_gap        <= WordGapRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegElementEndGap: cfg_q.element_end_gap <= cfg_wdata_i;
        RegDotMax:        cfg_q.dot_max         <= cfg_wdata_i;
        RegLetterGap:     cfg_q.letter_gap      <= cfg_wdata_i;
        RegWordGap:       cfg_q.word_gap        <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  mktd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_i     (q_full),
    .key_down_i (key_down_i),
    .cfg_i      (cfg_q),
    .q_push_o   (q_push),
    .q_data_o   (q_data)
  );

  mktd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_data),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  mktd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_head_i      (q_head),
    .q_pop_o       (q_pop),
    .pop_i         (pop && out_valid),
    .valid_o       (out_valid),
    .char_code_o   (char_code_o),
    .last_of_run_o (last_of_run_o)
  );

  assign full  = q_full;
  assign empty = !out_valid;

  // queue never written while full
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_push && q_full))
    else $error("queue written while full");

  // back end pops only a queue that holds a bundle
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("queue popped while empty");

  // with nothing queued, a taken character leaves the output empty
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_empty && pop && !empty) |=> empty)
    else $error("character shown without a queued bundle");

endmodule

// File: sim/morse_key_timing_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morse_key_timing_decoder_tb: self-checking bench for the key timing decoder
// Drives key samples through the input queue and predicts every character,
// prosign, apostrophe pair and space from the bench's own copy of the timing
// state. Checks each popped character in order. The run covers cascaded
// gaps, a deferred space after a full prosign, saturated element counts,
// unreachable thresholds and random well-formed letters under back-pressure.
// ----------------------------------------------------------------------------
module morse_key_timing_decoder_tb;
  import mktd_pkg::*;

  localparam int ClkPeriod    = 20;
  localparam int StallLimit   = 4000;
  localparam int HoldCycles   = 250;
  localparam int ItemTarget   = 230;
  localparam int CharTarget   = 60;
  localparam int ItemCap      = 3000;
  localparam int SettleCycles = 8;
  localparam logic [RegWidth-1:0] RegTop = {RegWidth{1'b1}};
  localparam logic [RegWidth-1:0] RegOne = RegWidth'(1);

  typedef enum logic [1:0] {KeyIdle, KeyTone, KeyLetterGap, KeyWordGap} key_phase_e;

  typedef struct packed {
    logic [6:0] code;
    logic       last;
  } char_req_t;

  // expected text built from accepted key samples
  class decoded_text_sb;
    logic [RegWidth-1:0]   end_gap, dot_limit, letter_limit, word_limit;
    key_phase_e            phase;
    logic [CountWidth-1:0] down_cnt, up_cnt;
    logic [5:0]            elem_bits;
    logic [2:0]            elem_cnt;
    char_req_t             expected_chars[$];
    int                    keys_seen, chars_due, mismatches;

    function new();
      end_gap      = ElementEndGapRst;
      dot_limit    = DotMaxRst;
      letter_limit = LetterGapRst;
      word_limit   = WordGapRst;
      phase        = KeyIdle;
      down_cnt     = '0;
      up_cnt       = '0;
      elem_bits    = '0;
      elem_cnt     = '0;
      keys_seen    = 0;
      chars_due    = 0;
      mismatches   = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [RegWidth-1:0] val);
      case (idx)
        RegElementEndGap: end_gap = val;
        RegDotMax:        dot_limit = val;
        RegLetterGap:     letter_limit = val;
        RegWordGap:       word_limit = val;
        default: ;
      endcase
    endfunction

    // element pattern to text, bit i is element i and 1 is a dash
    function string pattern_text(logic [2:0] cnt, logic [5:0] bits);
      string s;
      s = "";
      case (cnt)
        3'd1: case (bits)
          6'd0: s = "E";  6'd1: s = "T";
          default: ;
        endcase
        3'd2: case (bits)
          6'd0: s = "I";  6'd2: s = "A";  6'd1: s = "N";  6'd3: s = "M";
          default: ;
        endcase
        3'd3: case (bits)
          6'd0: s = "S";  6'd4: s = "U";  6'd2: s = "R";  6'd6: s = "W";
          6'd1: s = "D";  6'd5: s = "K";  6'd3: s = "G";  6'd7: s = "O";
          default: ;
        endcase
        3'd4: case (bits)
          6'd0: s = "H";  6'd8: s = "V";  6'd4: s = "F";  6'd2: s = "L";
          6'd6: s = "P";  6'd14: s = "J"; 6'd1: s = "B";  6'd9: s = "X";
          6'd5: s = "C";  6'd13: s = "Y"; 6'd3: s = "Z";  6'd11: s = "Q";
          default: ;
        endcase
        3'd5: case (bits)
          6'd0: s = "5";  6'd16: s = "4"; 6'd24: s = "3"; 6'd28: s = "2";
          6'd30: s = "1"; 6'd31: s = "0"; 6'd15: s = "9"; 6'd7: s = "8";
          6'd3: s = "7";  6'd1: s = "6";  6'd13: s = "("; 6'd9: s = "/";
          6'd17: s = "<BT>"; 6'd2: s = "<AS>"; 6'd10: s = "<AR>";
          default: ;
        endcase
        3'd6: case (bits)
          6'd0: s = "#";  6'd42: s = "."; 6'd51: s = ","; 6'd12: s = "?";
          6'd18: s = "''"; 6'd7: s = ":"; 6'd21: s = ";"; 6'd45: s = ")";
          6'd40: s = "<SK>";
          default: ;
        endcase
        default: ;
      endcase
      return s;
    endfunction

    function logic [CountWidth-1:0] bump(logic [CountWidth-1:0] v);
      return (v == CountTop) ? v : v + 1'b1;
    endfunction

    function void start_tone();
      down_cnt = CountWidth'(1);
      up_cnt   = '0;
      phase    = KeyTone;
    endfunction

    // one accepted key sample: advance timing state, queue its characters
    function void note_key(bit key);
      char_req_t run[$];
      char_req_t r;
      string     text;
      byte       c;
      bit        decoded;
      int        k;
      decoded = 1'b0;
      keys_seen++;
      case (phase)
        KeyIdle: begin
          if (key) start_tone();
          return;
        end
        KeyTone: begin
          if (key) down_cnt = bump(down_cnt);
          else up_cnt = bump(up_cnt);
          if (up_cnt <= end_gap) return;
          if (elem_cnt < 3'd6) elem_bits[elem_cnt] = (down_cnt > dot_limit);
          if (elem_cnt < 3'd7) elem_cnt++;
          phase = KeyLetterGap;
        end
        default: begin
          if (key) begin
            start_tone();
            return;
          end
          up_cnt = bump(up_cnt);
        end
      endcase
      // letter gap passed: decode the pattern
      if (phase == KeyLetterGap && up_cnt > letter_limit) begin
        text = pattern_text(elem_cnt, elem_bits);
        for (k = 0; k < text.len() && run.size() < 4; k++) begin
          c      = text[k];
          r.code = c[6:0];
          r.last = 1'b0;
          run.push_back(r);
        end
        elem_bits = '0;
        elem_cnt  = '0;
        decoded   = 1'b1;
        phase     = KeyWordGap;
      end
      // word gap passed: space, deferred when the decode used every slot
      if (phase == KeyWordGap && up_cnt > word_limit && (!decoded || run.size() < 4)) begin
        r.code = CharSpace;
        r.last = 1'b0;
        run.push_back(r);
        phase    = KeyIdle;
        down_cnt = '0;
        up_cnt   = '0;
      end
      if (run.size() > 0) run[run.size()-1].last = 1'b1;
      foreach (run[i]) expected_chars.push_back(run[i]);
      chars_due += run.size();
    endfunction

    function void log_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    // one popped character against the oldest expectation
    function void check_char(logic [6:0] code, logic last);
      char_req_t want;
      if (expected_chars.size() == 0) begin
        log_mismatch($sformatf("unexpected char 0x%02h last %0b", code, last));
        return;
      end
      want = expected_chars.pop_front();
      if (code !== want.code || last !== want.last)
        log_mismatch($sformatf("char 0x%02h last %0b, expected 0x%02h last %0b",
                               code, last, want.code, want.last));
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction
  endclass

  logic                clk, rst_n;
  logic                push, full, key_down;
  logic                empty, pop;
  logic [6:0]          char_code;
  logic                last_of_run;
  logic                cfg_we;
  logic [1:0]          cfg_idx;
  logic [RegWidth-1:0] cfg_wdata;

  decoded_text_sb sb;
  int             idle_cycles = 0;
  bit             hold_req = 1'b0;
  bit             steady_send = 1'b0;

  morse_key_timing_decoder u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .push         (push),
    .full         (full),
    .key_down_i   (key_down),
    .empty        (empty),
    .pop          (pop),
    .char_code_o  (char_code),
    .last_of_run_o(last_of_run),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #(ClkPeriod / 2) clk = ~clk;
  end

  // request monitors on both queues
  always @(posedge clk) begin
    if (rst_n && push && !full) sb.note_key(key_down);
    if (rst_n && pop && !empty) sb.check_char(char_code, last_of_run);
  end

  // watchdog on cycles without any accepted request
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("morse_key_timing_decoder_tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: random pop runs, plus one long hold-off on request
  initial begin
    int run_left;
    int hold_left;
    bit run_val;
    run_left  = 0;
    hold_left = 0;
    run_val   = 1'b0;
    pop <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        if (run_left == 0) begin
          run_val = ~run_val;
          if (run_val)
            run_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 24);
          else
            run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                                   : $urandom_range(1, 3);
        end
        run_left--;
        pop <= run_val;
      end
    end
  end

  // one key sample request, then an optional gap
  task automatic send_key(bit key);
    int gap;
    push     <= 1'b1;
    key_down <= key;
    do @(posedge clk); while (full);
    if (!steady_send && $urandom_range(0, 1) == 1) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_noise(int n);
    repeat (n) send_key(1'($urandom_range(0, 1)));
  endtask

  // one tone element, sometimes with a short key bounce inside it
  task automatic send_element(bit dash);
    int downs, cap, bounce;
    cap = (sb.dot_limit < 3) ? int'(sb.dot_limit) : 3;
    if (dash && sb.dot_limit < 8) downs = int'(sb.dot_limit) + $urandom_range(1, 2);
    else downs = $urandom_range(1, cap);
    bounce = (sb.end_gap >= 2 && downs >= 2 && $urandom_range(0, 5) == 0) ? 1 : 0;
    send_key(1'b1);
    if (bounce == 1) send_key(1'b0);
    repeat (downs - 1) send_key(1'b1);
    repeat (int'(sb.end_gap) + 1 - bounce) send_key(1'b0);
  endtask

  // a letter of len elements, then its letter gap and optionally the word gap
  task automatic send_char(int len, logic [6:0] bits, bit to_word);
    int i, sent_up, extra;
    for (i = 0; i < len; i++) send_element(bits[i]);
    if (sb.letter_limit <= 64) begin
      extra = (sb.letter_limit > sb.end_gap) ? int'(sb.letter_limit - sb.end_gap) : 0;
      repeat (extra) send_key(1'b0);
      sent_up = (sb.letter_limit > sb.end_gap) ? int'(sb.letter_limit) : int'(sb.end_gap);
      if (to_word && sb.word_limit <= 64) begin
        extra = (int'(sb.word_limit) > sent_up) ? int'(sb.word_limit) - sent_up : 0;
        repeat (extra + $urandom_range(0, 1)) send_key(1'b0);
      end
    end
  endtask

  // a known pattern, weighted toward the multi-character ones
  function automatic void pick_pattern(output logic [2:0] len, output logic [5:0] bits);
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 4))
        0: begin len = 3'd5; bits = 6'd17; end
        1: begin len = 3'd5; bits = 6'd2;  end
        2: begin len = 3'd5; bits = 6'd10; end
        3: begin len = 3'd6; bits = 6'd40; end
        default: begin len = 3'd6; bits = 6'd18; end
      endcase
    end else begin
      do begin
        len  = 3'($urandom_range(1, 6));
        bits = 6'($urandom_range(0, (1 << len) - 1));
      end while (sb.pattern_text(len, bits) == "");
    end
  endfunction

  // wait until every expected char has been popped and the pipe has settled
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [RegWidth-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic write_settings(logic [RegWidth-1:0] eeg, dmax, lgap, wgap);
    drain();
    write_reg(RegElementEndGap, eeg);
    write_reg(RegDotMax, dmax);
    write_reg(RegLetterGap, lgap);
    write_reg(RegWordGap, wgap);
    cfg_we <= 1'b0;
  endtask

  // stimulus
  initial begin
    logic [2:0]          len;
    logic [5:0]          bits;
    logic [RegWidth-1:0] eeg, dmax, lgap, wgap;
    int                  phase_no;
    sb = new();
    rst_n     <= 1'b0;
    push      <= 1'b0;
    key_down  <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_idx   <= '0;
    cfg_wdata <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // element, letter and word gap all passed on one up sample
    write_settings(RegOne, RegOne, RegOne, RegOne);
    send_key(1'b1);
    send_key(1'b0);
    send_key(1'b0);

    // prosign fills all four slots, space follows on the next up sample
    write_settings(RegOne, RegOne, RegWidth'(3), RegWidth'(3));
    send_char(5, 7'd2, 1'b0);
    send_key(1'b0);

    // top thresholds are never passed
    write_settings(RegTop, RegTop, RegTop, RegTop);
    send_noise(8);

    // no decode: elements pile up past the longest pattern
    write_settings(RegOne, RegTop, RegTop, RegTop);
    send_char(7, 7'($urandom_range(0, 127)), 1'b0);
    send_noise(6);

    // letters decode but a word never ends
    write_settings(RegOne, RegOne, RegWidth'(2), RegTop);
    send_char(2, 7'd2, 1'b0);
    send_char(1, 7'd1, 1'b0);

    // random settings and mostly well-formed letters
    phase_no = 0;
    while ((sb.keys_seen < ItemTarget || sb.chars_due < CharTarget) &&
           sb.keys_seen < ItemCap) begin
      if (phase_no == 0) begin
        // receiver holds off while letters keep coming, input backs up
        write_settings(RegOne, RegOne, RegWidth'(2), RegWidth'(2));
        steady_send = 1'b1;
        hold_req    = 1'b1;
        repeat (8) begin
          pick_pattern(len, bits);
          send_char(int'(len), {1'b0, bits}, 1'b1);
        end
      end else begin
        eeg  = RegWidth'($urandom_range(1, 3));
        dmax = RegWidth'($urandom_range(1, 3));
        lgap = ($urandom_range(0, 4) == 0) ? RegWidth'($urandom_range(1, eeg))
                                           : RegWidth'(eeg + $urandom_range(1, 4));
        case ($urandom_range(0, 9))
          0, 1, 2: wgap = lgap;
          3:       wgap = RegWidth'($urandom_range(1, lgap));
          default: wgap = RegWidth'(lgap + $urandom_range(1, 4));
        endcase
        case ($urandom_range(0, 11))
          0: dmax = RegTop;
          1: lgap = RegTop;
          2: wgap = RegTop;
          default: ;
        endcase
        write_settings(eeg, dmax, lgap, wgap);
        steady_send = ($urandom_range(0, 4) == 0);
        repeat ($urandom_range(3, 6)) begin
          if (sb.keys_seen >= ItemTarget && sb.chars_due >= CharTarget) break;
          case ($urandom_range(0, 19))
            0, 1, 2: send_noise($urandom_range(1, 12));
            3:       send_char(7, 7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
            4: begin
              len = 3'($urandom_range(1, 6));
              send_char(int'(len), 7'($urandom_range(0, (1 << len) - 1)), 1'b1);
            end
            default: begin
              pick_pattern(len, bits);
              send_char(int'(len), {1'b0, bits}, $urandom_range(0, 9) < 7);
            end
          endcase
        end
      end
      steady_send = 1'b0;
      phase_no++;
    end

    drain();
    if (sb.mismatches == 0)
      $display("morse_key_timing_decoder_tb: done, clean");
    else
      $display("morse_key_timing_decoder_tb: done, errors");
    $finish;
  end

endmodule

// File: files.f
hdl/mktd_pkg.sv
hdl/mktd_front.sv
hdl/mktd_queue.sv
hdl/mktd_back.sv
hdl/morse_key_timing_decoder.sv
sim/morse_key_timing_decoder_tb.sv
